FILE: sv/dogc_pkg.sv
// package for the degree ordered graph coloring unit
// holds widths, defaults, register indexes and the controller state type
// no dependencies
package dogc_pkg;

    // default sizing
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COLOR_BITS   = 4;

    // fixed field widths
    localparam int CNT_W  = 7;   // vertex counts, degrees, search depth
    localparam int VID_W  = 6;   // vertex number fields
    localparam int COL_W  = 4;   // color fields and color limit register
    localparam int CFG_W  = 7;   // configuration write data

    // configuration register indexes
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_COLOR_LIMIT  = 1'b1;

    // register reset values
    localparam logic [CNT_W-1:0] RST_VERTEX_COUNT = 7'd64;
    localparam logic [COL_W-1:0] RST_COLOR_LIMIT  = 4'd15;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WR_A,
        S_WR_B,
        S_ORD,
        S_SR_FETCH,
        S_SR_ROW,
        S_SR_CAP,
        S_SR_SCAN,
        S_SR_PICK,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT,
        S_CLEAR
    } t_state;

endpackage

FILE: sv/dogc_ram.sv
// generic simple dual port ram, one write and one registered read port
// used for the adjacency rows, visit order and vertex colors
// no dependencies
module dogc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/degree_ordered_graph_coloring_unit.sv
// top level of the degree ordered graph coloring unit
// depends on dogc_pkg and dogc_ram
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one edge per
// transfer; a transfer with i_final_edge set closes the graph and starts the
// coloring. Results leave on the output channel (o_out_valid / i_out_ready),
// one per vertex in ascending order, the last one flagged by o_last_result.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// the block is idle.
// Flow: an edge transfer passes through the accept and two read-modify-write
// states on the adjacency ram (S_WR_A, S_WR_B). After the final transfer the
// ordering pass scans adjacency rows once per cycle for each degree from n
// down towards 0 until every vertex is placed. Each search step scans the
// color ram over all vertices; the number of steps depends on the graph.
// Each result passes through a color ram read, a load of the result
// register and the transfer. The input is not ready from the final transfer
// until the last result is taken.
// Reset clears the adjacency and color stores through per-row valid bits,
// so no clearing pass is needed. A stalled receiver simply holds the result
// register and the block waits.
module degree_ordered_graph_coloring_unit #(
    parameter int MAX_VERTICES = dogc_pkg::DEF_MAX_VERTICES,
    parameter int COLOR_BITS   = dogc_pkg::DEF_COLOR_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [dogc_pkg::CFG_W-1:0] i_cfg_data,
    // edge input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_edge_present,
    input  logic [dogc_pkg::VID_W-1:0] i_end_a,
    input  logic [dogc_pkg::VID_W-1:0] i_end_b,
    input  logic                      i_final_edge,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [dogc_pkg::VID_W-1:0] o_vertex_id,
    output logic [dogc_pkg::COL_W-1:0] o_assigned_color,
    output logic                      o_found,
    output logic                      o_last_result
);

    localparam int NV   = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int IW   = $clog2(NV);
    localparam int CB   = COLOR_BITS;
    localparam int NCOL = 1 << CB;
    localparam int NC   = (NV + 7) / 8;
    localparam int CW   = dogc_pkg::CNT_W;

    // state
    dogc_pkg::t_state r_state, n_state;

    // configuration registers
    logic [CW-1:0]               r_vertex_count, n_vertex_count;
    logic [dogc_pkg::COL_W-1:0]  r_color_limit, n_color_limit;

    // edge load
    logic [IW-1:0] r_a, n_a, r_b, n_b;
    logic          r_final, n_final;
    logic [NV-1:0] r_rowa, n_rowa;

    // store valid bits and registered read addresses
    logic [NV-1:0] r_adj_vld, n_adj_vld;
    logic [NV-1:0] r_col_vld, n_col_vld;
    logic [IW-1:0] r_adj_ra, r_col_ra;

    // ordering pass
    logic [CW-1:0] r_i, n_i, r_d, n_d, r_pos, n_pos;
    logic          r_p1_v, n_p1_v, r_p2_v, n_p2_v;
    logic [IW-1:0] r_p1_i, n_p1_i, r_p2_i, n_p2_i;
    logic [CW-1:0] r_p1_d, n_p1_d, r_p2_d, n_p2_d;
    logic [3:0]    r_chunk [NC];
    logic [3:0]    n_chunk [NC];

    // search
    logic [CW-1:0]   r_depth, n_depth;
    logic [IW-1:0]   r_v, n_v;
    logic [NV-1:0]   r_row, n_row;
    logic [CW-1:0]   r_u, n_u;
    logic            r_s_v, n_s_v;
    logic [IW-1:0]   r_s_u, n_s_u;
    logic [NCOL-1:0] r_mask, n_mask;
    logic [CB-1:0]   r_cur, n_cur;
    logic            r_found, n_found;

    // output
    logic [CW-1:0]              r_oi, n_oi;
    logic                       r_out_valid, n_out_valid;
    logic [dogc_pkg::VID_W-1:0] r_out_id, n_out_id;
    logic [dogc_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic                       r_out_found, n_out_found;
    logic                       r_out_last, n_out_last;

    // ram ports
    logic          adj_we, vo_we, col_we;
    logic [IW-1:0] adj_waddr, adj_raddr, vo_waddr, vo_raddr, col_waddr, col_raddr;
    logic [NV-1:0] adj_wdata, adj_rdata, adj_row;
    logic [IW-1:0] vo_wdata, vo_rdata;
    logic [CB-1:0] col_wdata, col_rdata, col_rd;

    // derived values
    logic [CW-1:0] n_eff;
    logic [NV-1:0] nmask;
    logic [7:0]    lim8;
    logic [CW-1:0] deg_sum;
    logic          pick_ok;
    logic [CB-1:0] pick_col;
    logic          edge_ok;
    logic [7:0]    col_wide;

    dogc_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    dogc_ram #(.WIDTH(IW), .DEPTH(NV)) u_order_ram (
        .i_clk  (i_clk),
        .i_we   (vo_we),
        .i_waddr(vo_waddr),
        .i_wdata(vo_wdata),
        .i_raddr(vo_raddr),
        .o_rdata(vo_rdata)
    );

    dogc_ram #(.WIDTH(CB), .DEPTH(NV)) u_color_ram (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_waddr(col_waddr),
        .i_wdata(col_wdata),
        .i_raddr(col_raddr),
        .o_rdata(col_rdata)
    );

    // rows and colors never written since the last clear read as zero
    assign adj_row = r_adj_vld[r_adj_ra] ? adj_rdata : '0;
    assign col_rd  = r_col_vld[r_col_ra] ? col_rdata : '0;

    // effective vertex count and color limit
    assign n_eff = (r_vertex_count > CW'(NV)) ? CW'(NV) : r_vertex_count;
    assign lim8  = ({4'b0, r_color_limit} > 8'(NCOL - 1)) ? 8'(NCOL - 1)
                                                          : {4'b0, r_color_limit};

    // vertices below the effective count
    always_comb begin
        for (int j = 0; j < NV; j++) begin
            nmask[j] = (CW'(j) < n_eff);
        end
    end

    // degree sum of the registered chunk counts
    always_comb begin
        deg_sum = '0;
        for (int k = 0; k < NC; k++) begin
            deg_sum = deg_sum + CW'(r_chunk[k]);
        end
    end

    // lowest free color above the current one, none on a self-loop
    always_comb begin
        pick_ok  = 1'b0;
        pick_col = '0;
        for (int c = NCOL - 1; c >= 1; c--) begin
            if (8'(c) > 8'(r_cur) && 8'(c) <= lim8 && !r_mask[c]) begin
                pick_ok  = 1'b1;
                pick_col = CB'(c);
            end
        end
        if (r_row[r_v]) begin
            pick_ok = 1'b0;
        end
    end

    assign edge_ok = i_edge_present && ({1'b0, i_end_a} < CW'(NV))
                     && ({1'b0, i_end_b} < CW'(NV));
    assign col_wide = 8'(col_rd);

    // next state and datapath control
    always_comb begin
        n_state        = r_state;
        n_vertex_count = r_vertex_count;
        n_color_limit  = r_color_limit;
        n_a            = r_a;
        n_b            = r_b;
        n_final        = r_final;
        n_rowa         = r_rowa;
        n_adj_vld      = r_adj_vld;
        n_col_vld      = r_col_vld;
        n_i            = r_i;
        n_d            = r_d;
        n_pos          = r_pos;
        n_p1_v         = 1'b0;
        n_p1_i         = r_p1_i;
        n_p1_d         = r_p1_d;
        n_p2_v         = 1'b0;
        n_p2_i         = r_p1_i;
        n_p2_d         = r_p1_d;
        n_chunk        = r_chunk;
        n_depth        = r_depth;
        n_v            = r_v;
        n_row          = r_row;
        n_u            = r_u;
        n_s_v          = 1'b0;
        n_s_u          = r_s_u;
        n_mask         = r_mask;
        n_cur          = r_cur;
        n_found        = r_found;
        n_oi           = r_oi;
        n_out_valid    = r_out_valid;
        n_out_id       = r_out_id;
        n_out_col      = r_out_col;
        n_out_found    = r_out_found;
        n_out_last     = r_out_last;
        adj_we         = 1'b0;
        adj_waddr      = r_a;
        adj_wdata      = adj_row;
        adj_raddr      = r_adj_ra;
        vo_we          = 1'b0;
        vo_waddr       = r_pos[IW-1:0];
        vo_wdata       = r_p2_i;
        vo_raddr       = r_depth[IW-1:0];
        col_we         = 1'b0;
        col_waddr      = r_v;
        col_wdata      = '0;
        col_raddr      = r_col_ra;
        o_in_ready     = 1'b0;

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                dogc_pkg::REG_VERTEX_COUNT: n_vertex_count = i_cfg_data;
                dogc_pkg::REG_COLOR_LIMIT:  n_color_limit  = i_cfg_data[dogc_pkg::COL_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            // wait for an edge transfer, read row a right away
            dogc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                adj_raddr  = i_end_a[IW-1:0];
                if (i_in_valid) begin
                    n_a     = i_end_a[IW-1:0];
                    n_b     = i_end_b[IW-1:0];
                    n_final = i_final_edge;
                    if (edge_ok) begin
                        n_state = dogc_pkg::S_WR_A;
                    end else if (i_final_edge) begin
                        n_i     = '0;
                        n_d     = n_eff;
                        n_pos   = '0;
                        n_state = dogc_pkg::S_ORD;
                    end
                end
            end
            // set bit b in row a, read row b
            dogc_pkg::S_WR_A: begin
                adj_we           = 1'b1;
                adj_waddr        = r_a;
                adj_wdata        = adj_row | ({{(NV-1){1'b0}}, 1'b1} << r_b);
                n_rowa           = adj_wdata;
                n_adj_vld[r_a]   = 1'b1;
                adj_raddr        = r_b;
                n_state          = dogc_pkg::S_WR_B;
            end
            // set bit a in row b, forwarding row a on a self-loop
            dogc_pkg::S_WR_B: begin
                adj_we         = 1'b1;
                adj_waddr      = r_b;
                adj_wdata      = ((r_b == r_a) ? r_rowa : adj_row)
                                 | ({{(NV-1){1'b0}}, 1'b1} << r_a);
                n_adj_vld[r_b] = 1'b1;
                if (r_final) begin
                    n_i     = '0;
                    n_d     = n_eff;
                    n_pos   = '0;
                    n_state = dogc_pkg::S_ORD;
                end else begin
                    n_state = dogc_pkg::S_IDLE;
                end
            end
            // degree ordering: for each degree falling, append matching vertices
            dogc_pkg::S_ORD: begin
                adj_raddr = r_i[IW-1:0];
                n_p1_v    = 1'b1;
                n_p1_i    = r_i[IW-1:0];
                n_p1_d    = r_d;
                if (r_i == n_eff - 1'b1) begin
                    n_i = '0;
                    n_d = r_d - 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                // chunk popcounts of the masked row
                n_p2_v = r_p1_v;
                for (int k = 0; k < NC; k++) begin
                    n_chunk[k] = '0;
                    for (int b = 0; b < 8; b++) begin
                        if (k * 8 + b < NV) begin
                            n_chunk[k] = n_chunk[k]
                                         + 4'(adj_row[k * 8 + b] & nmask[k * 8 + b]);
                        end
                    end
                end
                // append when the degree matches this pass
                if (r_p2_v && deg_sum == r_p2_d && r_pos < n_eff) begin
                    vo_we    = 1'b1;
                    vo_waddr = r_pos[IW-1:0];
                    vo_wdata = r_p2_i;
                    n_pos    = r_pos + 1'b1;
                end
                if (r_pos == n_eff) begin
                    n_p1_v  = 1'b0;
                    n_p2_v  = 1'b0;
                    n_depth = '0;
                    n_found = 1'b0;
                    n_state = dogc_pkg::S_SR_FETCH;
                end
            end
            // next vertex in visit order, or done
            dogc_pkg::S_SR_FETCH: begin
                if (r_depth == n_eff) begin
                    n_found = 1'b1;
                    n_oi    = '0;
                    n_state = dogc_pkg::S_OUT_RD;
                end else begin
                    vo_raddr = r_depth[IW-1:0];
                    n_state  = dogc_pkg::S_SR_ROW;
                end
            end
            // read the adjacency row of the vertex
            dogc_pkg::S_SR_ROW: begin
                n_v       = vo_rdata;
                adj_raddr = vo_rdata;
                n_state   = dogc_pkg::S_SR_CAP;
            end
            // capture the row and start the color scan
            dogc_pkg::S_SR_CAP: begin
                n_row   = adj_row;
                n_u     = '0;
                n_mask  = '0;
                n_cur   = '0;
                n_state = dogc_pkg::S_SR_SCAN;
            end
            // collect neighbor colors and the vertex's own color
            dogc_pkg::S_SR_SCAN: begin
                if (r_u < n_eff) begin
                    col_raddr = r_u[IW-1:0];
                    n_s_v     = 1'b1;
                    n_s_u     = r_u[IW-1:0];
                    n_u       = r_u + 1'b1;
                end
                if (r_s_v) begin
                    if (r_s_u == r_v) begin
                        n_cur = col_rd;
                    end else if (r_row[r_s_u]) begin
                        n_mask = r_mask | ({{(NCOL-1){1'b0}}, 1'b1} << col_rd);
                    end
                end
                if (r_u >= n_eff && !r_s_v) begin
                    n_state = dogc_pkg::S_SR_PICK;
                end
            end
            // place a color and go deeper, or uncolor and backtrack
            dogc_pkg::S_SR_PICK: begin
                col_we         = 1'b1;
                col_waddr      = r_v;
                n_col_vld[r_v] = 1'b1;
                if (pick_ok) begin
                    col_wdata = pick_col;
                    n_depth   = r_depth + 1'b1;
                    n_state   = dogc_pkg::S_SR_FETCH;
                end else begin
                    col_wdata = '0;
                    if (r_depth == '0) begin
                        n_found = 1'b0;
                        n_oi    = '0;
                        n_state = dogc_pkg::S_OUT_RD;
                    end else begin
                        n_depth = r_depth - 1'b1;
                        n_state = dogc_pkg::S_SR_FETCH;
                    end
                end
            end
            // read the color of the next vertex to report
            dogc_pkg::S_OUT_RD: begin
                if (r_oi == n_eff) begin
                    n_state = dogc_pkg::S_CLEAR;
                end else begin
                    col_raddr = r_oi[IW-1:0];
                    n_state   = dogc_pkg::S_OUT_LD;
                end
            end
            // load the result register
            dogc_pkg::S_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_id    = r_oi[dogc_pkg::VID_W-1:0];
                n_out_col   = r_found ? col_wide[dogc_pkg::COL_W-1:0] : '0;
                n_out_found = r_found;
                n_out_last  = (r_oi + 1'b1 == n_eff);
                n_oi        = r_oi + 1'b1;
                n_state     = dogc_pkg::S_OUT_WAIT;
            end
            // hold the result until the transfer
            dogc_pkg::S_OUT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = dogc_pkg::S_OUT_RD;
                end
            end
            // drop the graph and colors for the next run
            dogc_pkg::S_CLEAR: begin
                n_adj_vld = '0;
                n_col_vld = '0;
                n_depth   = '0;
                n_found   = 1'b0;
                n_state   = dogc_pkg::S_IDLE;
            end
            default: begin
                n_state = dogc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dogc_pkg::S_IDLE;
            r_vertex_count <= dogc_pkg::RST_VERTEX_COUNT;
            r_color_limit  <= dogc_pkg::RST_COLOR_LIMIT;
            r_adj_vld      <= '0;
            r_col_vld      <= '0;
            r_p1_v         <= 1'b0;
            r_p2_v         <= 1'b0;
            r_s_v          <= 1'b0;
            r_depth        <= '0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_i            <= '0;
            r_d            <= '0;
            r_pos          <= '0;
            r_u            <= '0;
            r_oi           <= '0;
            r_final        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_vertex_count <= n_vertex_count;
            r_color_limit  <= n_color_limit;
            r_adj_vld      <= n_adj_vld;
            r_col_vld      <= n_col_vld;
            r_p1_v         <= n_p1_v;
            r_p2_v         <= n_p2_v;
            r_s_v          <= n_s_v;
            r_depth        <= n_depth;
            r_found        <= n_found;
            r_out_valid    <= n_out_valid;
            r_i            <= n_i;
            r_d            <= n_d;
            r_pos          <= n_pos;
            r_u            <= n_u;
            r_oi           <= n_oi;
            r_final        <= n_final;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_rowa      <= n_rowa;
        r_adj_ra    <= adj_raddr;
        r_col_ra    <= col_raddr;
        r_p1_i      <= n_p1_i;
        r_p1_d      <= n_p1_d;
        r_p2_i      <= n_p2_i;
        r_p2_d      <= n_p2_d;
        r_chunk     <= n_chunk;
        r_v         <= n_v;
        r_row       <= n_row;
        r_s_u       <= n_s_u;
        r_mask      <= n_mask;
        r_cur       <= n_cur;
        r_out_id    <= n_out_id;
        r_out_col   <= n_out_col;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_vertex_id      = r_out_id;
    assign o_assigned_color = r_out_col;
    assign o_found          = r_out_found;
    assign o_last_result    = r_out_last;

endmodule

FILE: verif/dogc_checker.sv
// result checker for the degree ordered graph coloring unit
// tracks configuration writes and edge transfers, predicts the colorings
// depends on dogc_pkg
module dogc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [dogc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_edge_present,
    input  logic [dogc_pkg::VID_W-1:0]   i_end_a,
    input  logic [dogc_pkg::VID_W-1:0]   i_end_b,
    input  logic                         i_final_edge,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [dogc_pkg::VID_W-1:0]   i_vertex_id,
    input  logic [dogc_pkg::COL_W-1:0]   i_assigned_color,
    input  logic                         i_found,
    input  logic                         i_last_result,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [dogc_pkg::VID_W-1:0] vid;
        logic [dogc_pkg::COL_W-1:0] color;
        logic                       found;
        logic                       last;
    } t_vertex_result;

    t_vertex_result             awaited_colors[$];
    bit [63:0]                  adj_rows[64];
    logic [dogc_pkg::CNT_W-1:0] vcount_reg;
    logic [dogc_pkg::COL_W-1:0] limit_reg;
    int                         pushed_count = 0;
    int                         popped_count = 0;

    // true when color c on vertex v clashes with a neighbor or a self-loop
    function automatic bit color_clashes(int v, int c, int n, int col[64]);
        for (int u = 0; u < n; u++) begin
            if (adj_rows[v][u] && (u == v || col[u] == c)) return 1;
        end
        return 0;
    endfunction

    // degree ordering plus backtracking search, then queue one result per vertex
    function automatic void solve_coloring();
        int n, lim, depth, v, k;
        int deg[64], order[64], col[64];
        bit placed, done, solved;
        t_vertex_result r;
        n = (vcount_reg > 64) ? 64 : int'(vcount_reg);
        lim = limit_reg;
        for (int i = 0; i < 64; i++) begin
            deg[i] = 0;
            col[i] = 0;
            order[i] = 0;
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) deg[i] += adj_rows[i][j];
        // insertion sort, falling degree, lower vertex first on ties
        for (int i = 0; i < n; i++) begin
            k = i;
            while (k > 0 && deg[order[k-1]] < deg[i]) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        depth = 0;
        done = 0;
        solved = 0;
        while (!done) begin
            if (depth >= n) begin
                solved = 1;
                done = 1;
            end else begin
                v = order[depth];
                placed = 0;
                for (int c = col[v] + 1; c <= lim && !placed; c++) begin
                    if (!color_clashes(v, c, n, col)) begin
                        col[v] = c;
                        placed = 1;
                    end
                end
                if (placed) depth++;
                else begin
                    col[v] = 0;
                    if (depth == 0) done = 1;
                    else depth--;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.vid = i[dogc_pkg::VID_W-1:0];
            r.color = solved ? col[i][dogc_pkg::COL_W-1:0] : '0;
            r.found = solved;
            r.last = (i + 1 == n);
            awaited_colors.push_back(r);
            pushed_count++;
        end
        for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    endfunction

    assign o_pending = pushed_count - popped_count;

    // configuration and edge transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vcount_reg <= dogc_pkg::RST_VERTEX_COUNT;
            limit_reg <= dogc_pkg::RST_COLOR_LIMIT;
            for (int i = 0; i < 64; i++) adj_rows[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == dogc_pkg::REG_VERTEX_COUNT)
                    vcount_reg <= i_cfg_data[dogc_pkg::CNT_W-1:0];
                else limit_reg <= i_cfg_data[dogc_pkg::COL_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                if (i_edge_present) begin
                    adj_rows[i_end_a][i_end_b] = 1'b1;
                    adj_rows[i_end_b][i_end_a] = 1'b1;
                end
                if (i_final_edge) solve_coloring();
            end
        end
    end

    // result transfers against the oldest expectation
    initial o_fail_count = 0;
    always @(posedge i_clk) begin
        t_vertex_result exp_r;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (awaited_colors.size() == 0) begin
                $error("unexpected result transfer, vertex_id %0d", i_vertex_id);
                o_fail_count++;
            end else begin
                exp_r = awaited_colors.pop_front();
                popped_count++;
                if (i_vertex_id !== exp_r.vid) begin
                    $error("vertex_id expected %0d got %0d", exp_r.vid, i_vertex_id);
                    o_fail_count++;
                end
                if (i_assigned_color !== exp_r.color) begin
                    $error("assigned_color expected %0d got %0d", exp_r.color,
                           i_assigned_color);
                    o_fail_count++;
                end
                if (i_found !== exp_r.found) begin
                    $error("found expected %0d got %0d", exp_r.found, i_found);
                    o_fail_count++;
                end
                if (i_last_result !== exp_r.last) begin
                    $error("last_result expected %0d got %0d", exp_r.last, i_last_result);
                    o_fail_count++;
                end
            end
        end
    end

endmodule

FILE: verif/tb_degree_ordered_graph_coloring_unit.sv
// testbench top for the degree ordered graph coloring unit
// drives directed and random graphs, dogc_checker predicts and compares
// depends on dogc_pkg, dogc_checker and the unit itself
module tb_degree_ordered_graph_coloring_unit;

    localparam int QUIET_LIMIT = 300000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_index = dogc_pkg::REG_VERTEX_COUNT;
    logic [dogc_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_edge_present = 1'b0;
    logic [dogc_pkg::VID_W-1:0] i_end_a = '0;
    logic [dogc_pkg::VID_W-1:0] i_end_b = '0;
    logic                       i_final_edge = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [dogc_pkg::VID_W-1:0] o_vertex_id;
    logic [dogc_pkg::COL_W-1:0] o_assigned_color;
    logic                       o_found;
    logic                       o_last_result;
    int                         fail_count;
    int                         pending;
    int                         items_sent = 0;
    bit                         sender_calm = 0;

    always #5 i_clk = ~i_clk;

    degree_ordered_graph_coloring_unit u_top (.*);

    dogc_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_edge_present, .i_end_a, .i_end_b,
        .i_final_edge, .i_out_valid(o_out_valid), .i_out_ready, .i_vertex_id(o_vertex_id),
        .i_assigned_color(o_assigned_color), .i_found(o_found),
        .i_last_result(o_last_result), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, one long hold-off, one calm window
    always @(posedge i_clk) begin
        static int cyc = 0;
        static int hold = 0;
        static bit held_once = 0;
        cyc++;
        if (!held_once && o_out_valid) begin
            held_once = 1;
            hold = 400;
        end
        if (hold > 0) begin
            hold--;
            i_out_ready <= 1'b0;
        end else if (cyc > 6000 && cyc < 12000) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 36);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        static int quiet = 0;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(bit edge_on, int a, int b, bit last);
        while (!sender_calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_edge_present <= edge_on;
        i_end_a <= a[dogc_pkg::VID_W-1:0];
        i_end_b <= b[dogc_pkg::VID_W-1:0];
        i_final_edge <= last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // after a final transfer: hold the input until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic program_regs(int vcount, int limit);
        i_cfg_we <= 1'b1;
        i_cfg_index <= dogc_pkg::REG_VERTEX_COUNT;
        i_cfg_data <= vcount[dogc_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= dogc_pkg::REG_COLOR_LIMIT;
        i_cfg_data <= limit[dogc_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random graph with mostly in-range endpoints and some noise items
    // self-loops only with small color limits, so an exhaustive search stays short
    task automatic random_graph();
        int n, lim, edges, a, b;
        bit wide;
        wide = ($urandom_range(14) == 0);
        n = wide ? 64 : $urandom_range(7, 1);
        lim = wide ? 15 : (($urandom_range(9) == 0) ? 15 : $urandom_range(6, 0));
        if (wide && $urandom_range(1)) program_regs(127, lim);
        else program_regs(n, lim);
        edges = $urandom_range(10);
        for (int e = 0; e < edges; e++) begin
            if ($urandom_range(9) == 0) begin
                send_item(1'b0, $urandom_range(63), $urandom_range(63), 1'b0);
            end else begin
                a = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
                b = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
                if (a == b && a < n && (wide || lim > 3)) b = (a + 1) % n;
                send_item(1'b1, a, b, 1'b0);
            end
        end
        a = $urandom_range(n - 1);
        b = wide ? (a + 1) % 64 : $urandom_range(n - 1);
        if (!wide && a == b && lim > 3) b = (a + 1) % n;
        send_item($urandom_range(1), a, b, 1'b1);
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, end marker noise, final transfer carrying an edge
        send_item(1'b1, 0, 63, 1'b0);
        send_item(1'b1, 63, 0, 1'b0);
        send_item(1'b0, 63, 63, 1'b0);
        send_item(1'b1, 10, 20, 1'b1);
        // next graph offered at once, stalled behind the held results
        send_item(1'b1, 1, 2, 1'b0);
        send_item(1'b1, 3, 4, 1'b1);
        drain_results();
        // triangle with two colors
        program_regs(3, 2);
        send_item(1'b1, 0, 1, 1'b0);
        send_item(1'b1, 1, 2, 1'b0);
        send_item(1'b1, 2, 0, 1'b1);
        drain_results();
        // self-loop
        program_regs(4, 15);
        send_item(1'b1, 2, 2, 1'b1);
        drain_results();
        // empty graph count
        program_regs(0, 15);
        send_item(1'b0, 0, 0, 1'b1);
        drain_results();
        // zero color limit
        program_regs(2, 0);
        send_item(1'b0, 1, 1, 1'b1);
        drain_results();
        // count above the store size, single color
        program_regs(127, 1);
        send_item(1'b1, 0, 40, 1'b0);
        send_item(1'b1, 5, 63, 1'b0);
        send_item(1'b0, 0, 0, 1'b1);
        drain_results();
        // endpoint outside the graph plus a path
        program_regs(5, 3);
        send_item(1'b1, 1, 50, 1'b0);
        send_item(1'b1, 0, 1, 1'b0);
        send_item(1'b1, 1, 2, 1'b0);
        send_item(1'b1, 3, 4, 1'b1);
        drain_results();

        // random graphs, with a window of no sender idling
        while (items_sent < 420) begin
            sender_calm = (items_sent > 150 && items_sent < 230);
            random_graph();
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: degree_ordered_graph_coloring_unit.f
sv/dogc_pkg.sv
sv/dogc_ram.sv
sv/degree_ordered_graph_coloring_unit.sv
verif/dogc_checker.sv
verif/tb_degree_ordered_graph_coloring_unit.sv
